### rtl/pgh_pkg.sv
// Shared types and constants for the pyramid grid histogram match block.
package pgh_pkg;

  // Fixed field widths
  localparam int REQ_W       = 2;
  localparam int COORD_W     = 16;
  localparam int SCALE_W     = 32;
  localparam int OFFSET_W    = 48;
  localparam int LEVEL_W     = 3;
  localparam int INDEX_W     = 10;
  localparam int OUT_COUNT_W = 16;
  localparam int TOTAL_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;

  // Level is capped below this bound regardless of the build limit
  localparam int LEVEL_LIMIT = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCLUSIVE = 3'd5;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_MATCH  = 2'd2
  } req_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SWEEP_USED,
    ST_READ,
    ST_WB,
    ST_SWEEP_CNT,
    ST_DONE
  } state_t;

  // Input request payload
  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      last;
  } in_data_t;

  // Result payload
  typedef struct packed {
    logic [INDEX_W-1:0]     bin_index;
    logic [OUT_COUNT_W-1:0] bin_count;
    logic                   collision;
    logic                   matched;
    logic [TOTAL_W-1:0]     match_total;
    logic                   set_done;
  } out_data_t;

  // Update controls from the merge stage to the store sequencer
  typedef struct packed {
    logic               cnt_we;
    logic               used_we;
    logic               close_set;
    logic [TOTAL_W-1:0] running;
  } merge_ctl_t;

endpackage

### rtl/pgh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pgh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/pgh_lane.sv
// One quantizer lane: affine Q16.16 map of a coordinate to a clamped cell.
module pgh_lane
  import pgh_pkg::*;
#(
  parameter int CELL_W = 5
) (
  input  logic                       clk,
  input  logic                       mul_en,
  input  logic                       add_en,
  input  logic [SCALE_W-1:0]         scale,
  input  logic signed [OFFSET_W-1:0] offset,
  input  logic signed [COORD_W-1:0]  coord,
  input  logic [LEVEL_W-1:0]         lvl,
  output logic [CELL_W-1:0]          cell_out
);

  localparam int PROD_W = SCALE_W + 1 + COORD_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int HI_W   = SUM_W - 16;

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [SUM_W-1:0]  sum;
  logic [HI_W-1:0]          hi;
  logic [CELL_W-1:0]        top;
  logic [CELL_W-1:0]        cell_r, cell_nxt;

  // Scale times coordinate, unsigned scale widened to signed
  assign prod_nxt = PROD_W'($signed({1'b0, scale}) * coord);

  // Add offset, drop fraction, clamp into 0 .. 2^lvl - 1
  always_comb begin
    sum = SUM_W'(prod_r) + SUM_W'(offset);
    hi  = sum[SUM_W-1:16];
    top = {CELL_W{1'b1}} >> (CELL_W - int'(lvl));
    if (sum[SUM_W-1]) begin
      cell_nxt = '0;
    end else if (hi > HI_W'(top)) begin
      cell_nxt = top;
    end else begin
      cell_nxt = hi[CELL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
    if (add_en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

### rtl/pgh_merge.sv
// Merge stage: bin index from both lanes and the count/used update rule.
module pgh_merge
  import pgh_pkg::*;
#(
  parameter int CELL_W     = 5,
  parameter int COUNT_BITS = 16
) (
  input  logic [CELL_W-1:0]     cx,
  input  logic [CELL_W-1:0]     cy,
  input  logic [LEVEL_W-1:0]    lvl,
  input  logic [REQ_W-1:0]      req_type,
  input  logic                  last,
  input  logic                  excl,
  input  logic [COUNT_BITS-1:0] cnt_rd,
  input  logic [COUNT_BITS-1:0] used_rd,
  input  logic [TOTAL_W-1:0]    running,
  output logic [2*CELL_W-1:0]   idx,
  output logic [COUNT_BITS-1:0] cnt_wr,
  output logic [COUNT_BITS-1:0] used_wr,
  output merge_ctl_t            ctl,
  output out_data_t             result
);

  localparam int IDX_W = 2 * CELL_W;

  logic [COUNT_BITS:0] need;
  logic                hit;
  logic [TOTAL_W-1:0]  run_inc;

  // Combine the lane cells into a bin index
  assign idx = IDX_W'(cx) + (IDX_W'(cy) << lvl);

  // Saturating count bump, unused-count test and running total
  always_comb begin
    cnt_wr  = (&cnt_rd) ? cnt_rd : cnt_rd + 1'b1;
    used_wr = used_rd + 1'b1;
    need    = (COUNT_BITS+1)'(used_rd) + (COUNT_BITS+1)'(excl);
    hit     = (COUNT_BITS+1)'(cnt_rd) > need;
    run_inc = (&running) ? running : running + 1'b1;
  end

  // Build the result and the write controls per request kind
  always_comb begin
    result             = '0;
    result.match_total = running;
    ctl                = '0;
    ctl.running        = running;
    case (req_type)
      REQ_INSERT: begin
        result.bin_index = INDEX_W'(idx);
        result.bin_count = OUT_COUNT_W'(cnt_wr);
        result.collision = |cnt_rd;
        ctl.cnt_we       = 1'b1;
      end
      REQ_MATCH: begin
        result.bin_index   = INDEX_W'(idx);
        result.bin_count   = OUT_COUNT_W'(cnt_rd);
        result.matched     = hit;
        result.match_total = hit ? run_inc : running;
        result.set_done    = last;
        ctl.used_we        = hit;
        ctl.close_set      = last;
        ctl.running        = hit ? run_inc : running;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/pyramid_grid_histogram_match.sv
// Top level of the pyramid grid histogram match block.
//
// Requests enter on in_valid/in_ready with an in_data_t payload; each request
// gives exactly one result on out_valid/out_ready (out_data_t). Registers are
// written through cfg_we/cfg_index/cfg_data; the user must do so only while the
// block is idle, which the block itself does not enforce. Two quantizer lanes map
// x and y to cells (multiply, then add and clamp); the merge stage forms the bin
// index and applies the insert or match rule on a read-modify-write of the count
// and used stores. An accepted insert or match passes through the multiply, add,
// store read and writeback steps, and the writeback loads the result register;
// the block then returns to idle. A match that opens a set sweeps the used store
// before its store read (DEPTH entries, DEPTH = 4^min(MAX_LEVEL,5)); a clear
// sweeps the count store. An unused request code goes from the multiply step
// straight to the done state, which loads its result.
// After reset both stores are swept to zero across all DEPTH entries with in_ready
// low; configuration writes are taken meanwhile.
// A stalled receiver holds the result in the output register; the block
// finishes the request only once that register frees up, then returns to idle.
module pyramid_grid_histogram_match
  import pgh_pkg::*;
#(
  parameter int MAX_LEVEL  = 5,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_data_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_data_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LVL_MAX = (MAX_LEVEL < LEVEL_LIMIT - 1) ? MAX_LEVEL : LEVEL_LIMIT - 1;
  localparam int CELL_W  = LVL_MAX;
  localparam int IDX_W   = 2 * CELL_W;
  localparam int DEPTH   = 1 << IDX_W;

  // Configuration registers
  logic [SCALE_W-1:0]         scale_x_r, scale_y_r;
  logic signed [OFFSET_W-1:0] offset_x_r, offset_y_r;
  logic [LEVEL_W-1:0]         level_r;
  logic                       excl_r;
  logic [LEVEL_W-1:0]         lvl;

  // Control state
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   sweep_r, sweep_nxt;
  logic               sweep_last;
  logic               set_open_r, set_open_nxt;
  logic [TOTAL_W-1:0] running_r, running_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_data_t          out_r;
  in_data_t           in_r;

  // Datapath
  logic [CELL_W-1:0]     cx, cy;
  logic [IDX_W-1:0]      idx;
  logic [COUNT_BITS-1:0] cnt_rd, used_rd, cnt_wr, used_wr;
  merge_ctl_t            ctl;
  out_data_t             result;

  // Sequencer outputs
  logic             in_fire, out_free, out_load;
  logic             mul_en, add_en, rd_en;
  logic             cnt_we, used_we;
  logic [IDX_W-1:0] cnt_waddr, used_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata, used_wdata;

  assign lvl        = (level_r > LEVEL_W'(LVL_MAX)) ? LEVEL_W'(LVL_MAX) : level_r;
  assign sweep_last = &sweep_r;
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r  <= SCALE_W'(65536);
      scale_y_r  <= SCALE_W'(65536);
      offset_x_r <= '0;
      offset_y_r <= '0;
      level_r    <= '0;
      excl_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE_X:   scale_x_r  <= cfg_data[SCALE_W-1:0];
        CFG_OFFSET_X:  offset_x_r <= cfg_data[OFFSET_W-1:0];
        CFG_SCALE_Y:   scale_y_r  <= cfg_data[SCALE_W-1:0];
        CFG_OFFSET_Y:  offset_y_r <= cfg_data[OFFSET_W-1:0];
        CFG_LEVEL:     level_r    <= cfg_data[LEVEL_W-1:0];
        CFG_EXCLUSIVE: excl_r     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:       if (sweep_last) state_nxt = ST_IDLE;
      ST_IDLE:       if (in_valid) state_nxt = ST_MUL;
      ST_MUL: begin
        case (in_r.req_type)
          REQ_CLEAR:  state_nxt = ST_SWEEP_CNT;
          REQ_INSERT: state_nxt = ST_ADD;
          REQ_MATCH:  state_nxt = ST_ADD;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_ADD: begin
        if (in_r.req_type == REQ_MATCH && !set_open_r) begin
          state_nxt = ST_SWEEP_USED;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_SWEEP_USED: if (sweep_last) state_nxt = ST_READ;
      ST_READ:       state_nxt = ST_WB;
      ST_WB:         if (out_free) state_nxt = ST_IDLE;
      ST_SWEEP_CNT:  if (sweep_last) state_nxt = ST_DONE;
      ST_DONE:       if (out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_INIT;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready   = 1'b0;
    mul_en     = 1'b0;
    add_en     = 1'b0;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    cnt_we     = 1'b0;
    used_we    = 1'b0;
    cnt_waddr  = idx;
    used_waddr = idx;
    cnt_wdata  = cnt_wr;
    used_wdata = used_wr;
    sweep_nxt  = '0;
    case (state_r)
      ST_INIT: begin
        cnt_we     = 1'b1;
        used_we    = 1'b1;
        cnt_waddr  = sweep_r;
        used_waddr = sweep_r;
        cnt_wdata  = '0;
        used_wdata = '0;
        sweep_nxt  = sweep_r + 1'b1;
      end
      ST_IDLE:  in_ready = 1'b1;
      ST_MUL:   mul_en = 1'b1;
      ST_ADD:   add_en = 1'b1;
      ST_SWEEP_USED: begin
        used_we    = 1'b1;
        used_waddr = sweep_r;
        used_wdata = '0;
        sweep_nxt  = sweep_r + 1'b1;
      end
      ST_READ:  rd_en = 1'b1;
      ST_WB: begin
        out_load = out_free;
        cnt_we   = out_free && ctl.cnt_we;
        used_we  = out_free && ctl.used_we;
      end
      ST_SWEEP_CNT: begin
        cnt_we    = 1'b1;
        cnt_waddr = sweep_r;
        cnt_wdata = '0;
        sweep_nxt = sweep_r + 1'b1;
      end
      ST_DONE:  out_load = out_free;
      default: begin
      end
    endcase
  end

  // Set tracking and output register next values
  always_comb begin
    set_open_nxt  = set_open_r;
    running_nxt   = running_r;
    out_valid_nxt = out_valid_r;
    if (state_r == ST_SWEEP_USED && sweep_last) begin
      set_open_nxt = 1'b1;
      running_nxt  = '0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      running_nxt   = ctl.running;
      if (ctl.close_set) begin
        set_open_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      set_open_r  <= 1'b0;
      running_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      set_open_r  <= set_open_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    if (out_load) begin
      out_r <= result;
    end
  end

  // Quantizer lanes
  pgh_lane #(.CELL_W(CELL_W)) u_lane_x (
    .clk      (clk),
    .mul_en   (mul_en),
    .add_en   (add_en),
    .scale    (scale_x_r),
    .offset   (offset_x_r),
    .coord    (in_r.coord_x),
    .lvl      (lvl),
    .cell_out (cx)
  );

  pgh_lane #(.CELL_W(CELL_W)) u_lane_y (
    .clk      (clk),
    .mul_en   (mul_en),
    .add_en   (add_en),
    .scale    (scale_y_r),
    .offset   (offset_y_r),
    .coord    (in_r.coord_y),
    .lvl      (lvl),
    .cell_out (cy)
  );

  // Merge lanes and apply the bin update rule
  pgh_merge #(.CELL_W(CELL_W), .COUNT_BITS(COUNT_BITS)) u_merge (
    .cx       (cx),
    .cy       (cy),
    .lvl      (lvl),
    .req_type (in_r.req_type),
    .last     (in_r.last),
    .excl     (excl_r),
    .cnt_rd   (cnt_rd),
    .used_rd  (used_rd),
    .running  (running_r),
    .idx      (idx),
    .cnt_wr   (cnt_wr),
    .used_wr  (used_wr),
    .ctl      (ctl),
    .result   (result)
  );

  // Bin count and per-set used stores
  pgh_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (rd_en),
    .raddr (idx),
    .rdata (cnt_rd)
  );

  pgh_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_used_ram (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .re    (rd_en),
    .raddr (idx),
    .rdata (used_rd)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A finished request always returns the sequencer to idle
  a_wb_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_WB || state_r == ST_DONE) && out_load) |=> state_r == ST_IDLE)
    else $error("request did not return to idle after its result");

  // An insert never writes a zero count back
  a_insert_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && cnt_we) |-> cnt_wdata != '0)
    else $error("insert wrote a zero bin count");

  // The running total only steps by one or restarts with a new set
  a_running_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && running_r != $past(running_r)) |->
      (running_r == $past(running_r) + 1'b1 || running_r == '0))
    else $error("running match total jumped");

  // The end of a used-store sweep opens a set
  a_sweep_opens_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP_USED && sweep_last) |=> (set_open_r && state_r == ST_READ))
    else $error("used sweep did not open a set");

endmodule
